// ===== rtl/core/rbsi_pkg.sv =====
// Shared types and constants for the ray/box slab intersection unit.
// Beat structs, pipeline stage indices, register indices and Q16.16 limits.
// No dependencies.
package rbsi_pkg;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic [30:0]        distance;
		logic [1:0]         hit_axis;
		logic               face_positive;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} res_t;

	typedef logic signed [31:0] tval_t;

	localparam int NUM_AXES  = 3;
	localparam int NUM_W     = 34;   // centre - origin +/- half, exact
	localparam int REM_W     = 64;   // divider remainder
	localparam int DIV_STEPS = 32;   // one quotient bit per stage

	// pipeline stage indices
	localparam int ST_IN      = 0;
	localparam int ST_PREP    = 1;
	localparam int ST_DIV_END = ST_PREP + DIV_STEPS;
	localparam int ST_FIN     = ST_DIV_END + 1;
	localparam int ST_MERGE   = ST_FIN + 1;
	localparam int ST_MUL     = ST_MERGE + 1;
	localparam int ST_OUT     = ST_MUL + 1;
	localparam int NUM_STAGES = ST_OUT + 1;

	localparam tval_t T_MAX = 32'sh7FFF_FFFF;
	localparam tval_t T_MIN = 32'sh8000_0000;

	localparam logic [30:0] HALF_RESET = 31'd65536;

	localparam logic [2:0] CFG_HALF_X   = 3'd0;
	localparam logic [2:0] CFG_HALF_Y   = 3'd1;
	localparam logic [2:0] CFG_HALF_Z   = 3'd2;
	localparam logic [2:0] CFG_CENTRE_X = 3'd3;
	localparam logic [2:0] CFG_CENTRE_Y = 3'd4;
	localparam logic [2:0] CFG_CENTRE_Z = 3'd5;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

// ===== rtl/core/ray_box_slab_intersect_unit.sv =====
// Ray versus axis-aligned box, slab test in signed Q16.16, one ray per clock.
// A ray is taken on every cycle in which the result side keeps up; each ray
// passes the 32-step restoring divider pipeline in each of the three axis
// lanes (six dividers in all), then merge, multiply and output stages.
// Stalls close up bubbles stage by stage, so rays keep entering while a
// finished result waits. Box registers are written through the cfg port.
module ray_box_slab_intersect_unit import rbsi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ray_valid,
	output logic       ray_stall,
	input  ray_t       ray,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	logic [30:0] half_q   [NUM_AXES];
	tval_t       centre_q [NUM_AXES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				half_q[i]   <= HALF_RESET;
				centre_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HALF_X:   half_q[0]   <= cfg_data[30:0];
				CFG_HALF_Y:   half_q[1]   <= cfg_data[30:0];
				CFG_HALF_Z:   half_q[2]   <= cfg_data[30:0];
				CFG_CENTRE_X: centre_q[0] <= $signed(cfg_data);
				CFG_CENTRE_Y: centre_q[1] <= $signed(cfg_data);
				CFG_CENTRE_Z: centre_q[2] <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage occupancy and per-stage advance
	logic [NUM_STAGES-1:0] v_q, en;

	always_comb begin
		en[ST_OUT] = !v_q[ST_OUT] || !res_stall;
		for (int k = ST_OUT - 1; k >= 0; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[ST_IN])
				v_q[ST_IN] <= ray_valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k])
					v_q[k] <= v_q[k-1];
			end
		end
	end

	assign ray_stall = !en[ST_IN];
	assign res_valid = v_q[ST_OUT];

	// early miss: dot(origin, dir) > 0, exact
	logic signed [63:0] prod_s0 [NUM_AXES];
	logic               miss_s  [ST_FIN+1];
	ray_t               ray_s   [ST_FIN+1];

	always_ff @(posedge clk) begin
		if (en[ST_IN]) begin
			prod_s0[0] <= ray.origin_x * ray.dir_x;
			prod_s0[1] <= ray.origin_y * ray.dir_y;
			prod_s0[2] <= ray.origin_z * ray.dir_z;
			ray_s[0]   <= ray;
			// miss_s[0] is never read; keep it defined
			miss_s[0]  <= 1'b0;
		end
		if (en[ST_PREP]) begin
			miss_s[ST_PREP] <= (66'(prod_s0[0]) + 66'(prod_s0[1]) + 66'(prod_s0[2])) > 0;
			ray_s[ST_PREP]  <= ray_s[0];
		end
		for (int k = ST_PREP + 1; k <= ST_FIN; k++) begin
			if (en[k]) begin
				miss_s[k] <= miss_s[k-1];
				ray_s[k]  <= ray_s[k-1];
			end
		end
	end

	tval_t orig [NUM_AXES];
	tval_t dirv [NUM_AXES];
	tval_t t_lo [NUM_AXES];
	tval_t t_hi [NUM_AXES];

	always_comb begin
		orig[0] = ray.origin_x;
		orig[1] = ray.origin_y;
		orig[2] = ray.origin_z;
		dirv[0] = ray.dir_x;
		dirv[1] = ray.dir_y;
		dirv[2] = ray.dir_z;
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		rbsi_axis_lane u_lane (
			.clk      (clk),
			.en       (en),
			.origin   (orig[a]),
			.dir      (dirv[a]),
			.half     (half_q[a]),
			.centre   (centre_q[a]),
			.t_lo_s34 (t_lo[a]),
			.t_hi_s34 (t_hi[a])
		);
	end

	rbsi_merge u_merge (
		.clk     (clk),
		.en      (en),
		.t_lo    (t_lo),
		.t_hi    (t_hi),
		.ray     (ray_s[ST_FIN]),
		.miss    (miss_s[ST_FIN]),
		.res_s37 (res)
	);

	a_idle_out_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !ray_stall)
		else $error("input stalled with empty output stage");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.distance == 0 && res.hit_axis == 0 &&
			!res.face_positive && res.point_x == 0 && res.point_y == 0 &&
			res.point_z == 0)
		else $error("miss beat carries non-zero fields");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.hit_axis == AXIS_X || res.hit_axis == AXIS_Y ||
			res.hit_axis == AXIS_Z)
		else $error("hit axis out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result beat changed");

endmodule

// ===== rtl/core/rbsi_slab_div.sv =====
// Pipelined restoring divider: (num * 65536) / den, truncated, saturated to 32 bits.
// One set-up stage then one quotient bit per stage. Depends on rbsi_pkg.
module rbsi_slab_div import rbsi_pkg::*; (
	input  logic                    clk,
	input  logic [DIV_STEPS:0]      en,
	input  logic signed [NUM_W-1:0] num,
	input  tval_t                   den,
	output tval_t                   t
);

	logic [REM_W-1:0]     rem_s  [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] quo_s  [DIV_STEPS+1];
	logic [31:0]          dmag_s [DIV_STEPS+1];
	logic [DIV_STEPS:0]   nneg_s, dneg_s, dzero_s, ovf_s;

	logic [NUM_W-1:0] nmag;
	logic [31:0]      dmag;

	always_comb begin
		nmag = (num < 0) ? $unsigned(-num) : $unsigned(num);
		dmag = (den < 0) ? $unsigned(-den) : $unsigned(den);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]   <= REM_W'({nmag, 16'b0});
			quo_s[0]   <= '0;
			dmag_s[0]  <= dmag;
			nneg_s[0]  <= num < 0;
			dneg_s[0]  <= den < 0;
			dzero_s[0] <= den == 0;
			// quotient would need more than 32 bits
			ovf_s[0]   <= 48'(nmag) >= {dmag, 16'b0};
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		localparam int BIT = DIV_STEPS - k;
		logic [REM_W-1:0]     trial;
		logic                 ge;
		logic [DIV_STEPS-1:0] quo_nxt;

		always_comb begin
			trial        = REM_W'(dmag_s[k-1]) << BIT;
			ge           = rem_s[k-1] >= trial;
			quo_nxt      = quo_s[k-1];
			quo_nxt[BIT] = ge;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]   <= ge ? rem_s[k-1] - trial : rem_s[k-1];
				quo_s[k]   <= quo_nxt;
				dmag_s[k]  <= dmag_s[k-1];
				nneg_s[k]  <= nneg_s[k-1];
				dneg_s[k]  <= dneg_s[k-1];
				dzero_s[k] <= dzero_s[k-1];
				ovf_s[k]   <= ovf_s[k-1];
			end
		end
	end

	logic big;

	always_comb begin
		big = ovf_s[DIV_STEPS] || quo_s[DIV_STEPS][DIV_STEPS-1];
		if (dzero_s[DIV_STEPS])
			t = nneg_s[DIV_STEPS] ? T_MIN : T_MAX;
		else if (nneg_s[DIV_STEPS] ^ dneg_s[DIV_STEPS])
			t = big ? T_MIN : $signed(32'(-quo_s[DIV_STEPS]));
		else
			t = big ? T_MAX : $signed(32'(quo_s[DIV_STEPS]));
	end

endmodule

// ===== rtl/core/rbsi_axis_lane.sv =====
// One axis lane: slab numerators, two dividers, entry/exit ordering.
// Depends on rbsi_pkg and rbsi_slab_div.
module rbsi_axis_lane import rbsi_pkg::*; (
	input  logic                  clk,
	input  logic [NUM_STAGES-1:0] en,
	input  tval_t                 origin,
	input  tval_t                 dir,
	input  logic [30:0]           half,
	input  tval_t                 centre,
	output tval_t                 t_lo_s34,
	output tval_t                 t_hi_s34
);

	logic signed [NUM_W-1:0] base, num_a, num_b;
	logic signed [NUM_W-1:0] num_a_s0, num_b_s0;
	tval_t                   dir_s0;
	tval_t                   ta, tb;

	always_comb begin
		base  = NUM_W'(centre) - NUM_W'(origin);
		num_a = $signed(base - NUM_W'(half));
		num_b = $signed(base + NUM_W'(half));
	end

	always_ff @(posedge clk) begin
		if (en[ST_IN]) begin
			num_a_s0 <= num_a;
			num_b_s0 <= num_b;
			dir_s0   <= dir;
		end
	end

	rbsi_slab_div u_div_a (
		.clk (clk),
		.en  (en[ST_DIV_END:ST_PREP]),
		.num (num_a_s0),
		.den (dir_s0),
		.t   (ta)
	);

	rbsi_slab_div u_div_b (
		.clk (clk),
		.en  (en[ST_DIV_END:ST_PREP]),
		.num (num_b_s0),
		.den (dir_s0),
		.t   (tb)
	);

	always_ff @(posedge clk) begin
		if (en[ST_FIN]) begin
			t_lo_s34 <= (ta > tb) ? tb : ta;
			t_hi_s34 <= (ta > tb) ? ta : tb;
		end
	end

endmodule

// ===== rtl/core/rbsi_merge.sv =====
// Merging stage: greatest entry with its axis, least exit, hit point.
// Three stages: merge, multiply, add and saturate. Depends on rbsi_pkg.
module rbsi_merge import rbsi_pkg::*; (
	input  logic                  clk,
	input  logic [NUM_STAGES-1:0] en,
	input  tval_t                 t_lo [NUM_AXES],
	input  tval_t                 t_hi [NUM_AXES],
	input  ray_t                  ray,
	input  logic                  miss,
	output res_t                  res_s37
);

	tval_t      tmin, tmax;
	logic [1:0] axis;

	always_comb begin
		tmin = '0;
		tmax = T_MAX;
		axis = AXIS_X;
		for (int i = 0; i < NUM_AXES; i++) begin
			// strict compare: ties keep the earlier axis
			if (t_lo[i] > tmin) begin
				tmin = t_lo[i];
				axis = 2'(i);
			end
			if (t_hi[i] < tmax)
				tmax = t_hi[i];
		end
	end

	tval_t      tmin_s35;
	logic [1:0] axis_s35;
	logic       hit_s35;
	ray_t       ray_s35;

	always_ff @(posedge clk) begin
		if (en[ST_MERGE]) begin
			tmin_s35 <= tmin;
			axis_s35 <= axis;
			hit_s35  <= !miss && !(tmin > tmax);
			ray_s35  <= ray;
		end
	end

	logic signed [63:0] prod_s36 [NUM_AXES];
	tval_t              orig_s36 [NUM_AXES];
	tval_t              tmin_s36;
	logic [1:0]         axis_s36;
	logic               hit_s36, face_s36;
	tval_t              o_sel;

	always_comb begin
		case (axis_s35)
			AXIS_X:  o_sel = ray_s35.origin_x;
			AXIS_Y:  o_sel = ray_s35.origin_y;
			AXIS_Z:  o_sel = ray_s35.origin_z;
			default: o_sel = ray_s35.origin_x;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			prod_s36[0] <= tmin_s35 * ray_s35.dir_x;
			prod_s36[1] <= tmin_s35 * ray_s35.dir_y;
			prod_s36[2] <= tmin_s35 * ray_s35.dir_z;
			orig_s36[0] <= ray_s35.origin_x;
			orig_s36[1] <= ray_s35.origin_y;
			orig_s36[2] <= ray_s35.origin_z;
			tmin_s36    <= tmin_s35;
			axis_s36    <= axis_s35;
			hit_s36     <= hit_s35;
			face_s36    <= o_sel > 0;
		end
	end

	tval_t pt [NUM_AXES];

	always_comb begin
		logic signed [48:0] sum;
		for (int i = 0; i < NUM_AXES; i++) begin
			// arithmetic shift is floor division by 65536
			sum = 49'(orig_s36[i]) + 49'($signed(prod_s36[i][63:16]));
			if (sum > 49'sh0_7FFF_FFFF)
				pt[i] = T_MAX;
			else if (sum < -49'sh0_8000_0000)
				pt[i] = T_MIN;
			else
				pt[i] = sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			if (hit_s36) begin
				res_s37.hit           <= 1'b1;
				res_s37.distance      <= tmin_s36[30:0];
				res_s37.hit_axis      <= axis_s36;
				res_s37.face_positive <= face_s36;
				res_s37.point_x       <= pt[0];
				res_s37.point_y       <= pt[1];
				res_s37.point_z       <= pt[2];
			end else begin
				res_s37 <= '0;
			end
		end
	end

endmodule

// ===== sim/ray_box_slab_intersect_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ray_box_slab_intersect_unit: random and directed rays,
// box register sweeps, stalls on both sides. Needs rbsi_pkg and the unit RTL.
module ray_box_slab_intersect_unit_tb;
	import rbsi_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        ray_valid;
	logic        ray_stall;
	ray_t        ray;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	ray_box_slab_intersect_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int LATENCY = NUM_STAGES + 4;
	localparam longint CYCLE_LIMIT = 400000;

	longint box_half [3];
	longint box_centre [3];
	res_t   hits_due [$];
	int     mismatches;
	int     rays_sent;
	int     results_seen;
	int     hits_seen;
	longint cycles;
	bit     hold_off;
	int     hold_cycles;
	bit     stall_quiet;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint slab_param(longint num, longint d);
		if (d == 0) return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
		return clamp32((num * 65536) / d);
	endfunction

	function automatic longint floor_q16(longint v);
		return v >>> 16;
	endfunction

	function automatic res_t intersect_ray(ray_t r);
		res_t   o;
		longint org [3];
		longint dv [3];
		longint pos, neg, p, t1, t2, s, tmin, tmax, base;
		int     ax;
		o = '0;
		org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
		dv[0] = r.dir_x; dv[1] = r.dir_y; dv[2] = r.dir_z;
		pos = 0; neg = 0;
		// products fit in 63 bits, and three of them in an unsigned 64 sense
		for (int i = 0; i < 3; i++) begin
			p = org[i] * dv[i];
			if (p >= 0) pos += p; else neg -= p;
		end
		if ($unsigned(pos) > $unsigned(neg)) return o;
		tmin = 0; tmax = 64'sd2147483647; ax = 0;
		for (int i = 0; i < 3; i++) begin
			base = box_centre[i] - org[i];
			t1 = slab_param(base - box_half[i], dv[i]);
			t2 = slab_param(base + box_half[i], dv[i]);
			if (t1 > t2) begin
				s = t1; t1 = t2; t2 = s;
			end
			if (t1 > tmin) begin
				tmin = t1; ax = i;
			end
			if (t2 < tmax) tmax = t2;
		end
		if (tmin > tmax) return o;
		o.hit = 1'b1;
		o.distance = tmin[30:0];
		o.hit_axis = ax[1:0];
		o.face_positive = org[ax] > 0;
		o.point_x = 32'(clamp32(org[0] + floor_q16(tmin * dv[0])));
		o.point_y = 32'(clamp32(org[1] + floor_q16(tmin * dv[1])));
		o.point_z = 32'(clamp32(org[2] + floor_q16(tmin * dv[2])));
		return o;
	endfunction

	// cycle counter and watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("ray_box_slab_intersect_unit verification failed");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (hits_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", res);
			end else begin
				want = hits_due.pop_front();
				if (res.hit) hits_seen++;
				if (res.hit !== want.hit || res.distance !== want.distance ||
						res.hit_axis !== want.hit_axis ||
						res.face_positive !== want.face_positive ||
						res.point_x !== want.point_x || res.point_y !== want.point_y ||
						res.point_z !== want.point_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h got %h", want, res);
				end
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) res_stall <= 1'b0;
		else if (hold_off) begin
			res_stall <= 1'b1;
			hold_cycles++;
		end else if (stall_quiet) res_stall <= 1'b0;
		else res_stall <= ($urandom_range(0, 99) < 30);
	end

	task automatic send_ray(ray_t r);
		@(negedge clk);
		ray <= r;
		ray_valid <= 1'b1;
		@(posedge clk);
		while (ray_stall) @(posedge clk);
		hits_due.push_back(intersect_ray(r));
		rays_sent++;
		// burst gaps: now and then drop valid between rays
		if ($urandom_range(0, 7) == 0) begin
			@(negedge clk);
			ray_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		ray_valid <= 1'b0;
		while (hits_due.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= CFG_HALF_Z) box_half[idx] = {33'd0, val[30:0]};
		else box_centre[idx - 3] = $signed(val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_q(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default: return $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
		endcase
	endfunction

	// ray from a random origin aimed towards the region around zero, random content
	function automatic ray_t aimed_ray();
		ray_t r;
		int   m;
		m = $urandom_range(1, 2);
		r.origin_x = rand_q(m); r.origin_y = rand_q(m); r.origin_z = rand_q(m);
		r.dir_x = -r.origin_x + rand_q(1);
		r.dir_y = -r.origin_y + rand_q(1);
		r.dir_z = -r.origin_z + rand_q(1);
		if ($urandom_range(0, 3) == 0) r.dir_x = 0;
		if ($urandom_range(0, 3) == 0) r.dir_y = 0;
		return r;
	endfunction

	task automatic test_directed;
		ray_t r;
		r = '0; send_ray(r);                                   // all zero
		r = '{32'sh0002_0000, 0, 0, -32'sh0001_0000, 0, 0};   send_ray(r);
		r = '{0, 32'sh0003_0000, 0, 0, -32'sh0001_0000, 0};   send_ray(r);
		r = '{0, 0, -32'sh0003_0000, 0, 0, 32'sh0000_8000};   send_ray(r);
		r = '{32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 0};    send_ray(r); // away
		r = '{T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN};      send_ray(r);
		r = '{T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX};      send_ray(r);
		r = '{T_MIN, T_MAX, 0, T_MAX, T_MIN, 0};              send_ray(r);
		r = '{32'sh0002_0000, 32'sh0002_0000, 0, -32'sh1, -32'sh1, 0}; send_ray(r);
		r = '{32'sh0000_8000, 0, 0, 0, 0, 0};                 send_ray(r); // inside
		r = '{32'sh0002_0000, 32'sh0005_0000, 0, -32'sh1_0000, 0, 0}; send_ray(r);
		r = '{-32'sh1, -32'sh1, -32'sh1, 32'sh1, 32'sh1, 32'sh1}; send_ray(r);
		r = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
			-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000}; send_ray(r); // tie
		r = '{32'shFFFF_FFFF, 32'sh7FFF_0000, 32'sh0, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'sh1}; send_ray(r);
		drain();
	endtask

	task automatic test_random(int n);
		ray_t r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) != 0) r = aimed_ray();
			else begin
				r.origin_x = rand_q(0); r.origin_y = rand_q(0); r.origin_z = rand_q(0);
				r.dir_x = rand_q(0); r.dir_y = rand_q(0); r.dir_z = rand_q(0);
			end
			send_ray(r);
		end
		drain();
	endtask

	task automatic test_box_settings;
		// extremes of the box registers
		write_reg(CFG_HALF_X, 32'h7FFF_FFFF);
		write_reg(CFG_HALF_Y, 32'h0);
		write_reg(CFG_HALF_Z, 32'h0010_0000);
		write_reg(CFG_CENTRE_X, 32'h8000_0000);
		write_reg(CFG_CENTRE_Y, 32'h7FFF_FFFF);
		write_reg(CFG_CENTRE_Z, 32'hFFFF_0000);
		test_random(60);
		write_reg(CFG_HALF_X, 32'h0000_8000);
		write_reg(CFG_HALF_Y, 32'h0004_0000);
		write_reg(CFG_HALF_Z, 32'hFFFF_FFFF);
		write_reg(CFG_CENTRE_X, 32'h0001_0000);
		write_reg(CFG_CENTRE_Y, 32'h0);
		write_reg(CFG_CENTRE_Z, 32'h8000_0000);
		test_random(60);
		for (int k = 0; k < 3; k++) begin
			write_reg(CFG_HALF_X, $urandom_range(0, 32'h0008_0000));
			write_reg(CFG_HALF_Y, $urandom_range(0, 32'h0008_0000));
			write_reg(CFG_HALF_Z, $urandom_range(0, 32'h0008_0000));
			write_reg(CFG_CENTRE_X, rand_q(1));
			write_reg(CFG_CENTRE_Y, rand_q(1));
			write_reg(CFG_CENTRE_Z, rand_q(1));
			test_random(50);
		end
	endtask

	task automatic test_back_pressure;
		// receiver holds off long enough for the pipeline to fill and stall input
		ray_t r;
		hold_cycles = 0;
		hold_off = 1'b1;
		fork
			while (hold_cycles < 3 * NUM_STAGES) @(posedge clk);
			for (int i = 0; i < 60; i++) begin
				r = aimed_ray();
				send_ray(r);
			end
		join_any
		hold_off = 1'b0;
		wait fork;
		stall_quiet = 1'b1;
		test_random(40);
		stall_quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		ray_valid = 1'b0;
		ray = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HALF_X;
		cfg_data = '0;
		hold_off = 1'b0;
		stall_quiet = 1'b0;
		mismatches = 0;
		rays_sent = 0;
		results_seen = 0;
		hits_seen = 0;
		cycles = 0;
		for (int i = 0; i < 3; i++) begin
			box_half[i] = 65536;
			box_centre[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(60);
		test_back_pressure();
		test_box_settings();

		$display("%0d rays sent, %0d results checked, %0d hits, over %0d box settings",
			rays_sent, results_seen, hits_seen, 6);
		if (mismatches == 0 && hits_due.size() == 0)
			$display("ray_box_slab_intersect_unit verification clean");
		else begin
			$display("%0d mismatches, %0d results outstanding", mismatches, hits_due.size());
			$display("ray_box_slab_intersect_unit verification failed");
		end
		$finish;
	end

endmodule
